>>> sv/kce_pkg.sv
// shared types and constants of the keyspace candidate enumerator
package kce_pkg;

   localparam int CHAR_W     = 8;
   localparam int INDEX_W    = 6;
   localparam int FUNC_W     = 2;
   localparam int CAND_W     = 64;
   localparam int LEN_W      = 4;
   localparam int ATTEMPT_W  = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [FUNC_W-1:0] FUNC_LOAD_ALPHA = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_FIRST = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_NEXT       = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_RESTART    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH  = 2'd2;

   typedef struct packed {
      logic accept;
      logic start_fetch;
      logic capture;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic last_byte;
      logic out_free;
   } stat_type;

endpackage

>>> sv/kce_req_if.sv
// request channel of the enumerator
interface kce_req_if;
   import kce_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [INDEX_W-1:0]  entry_index;
   logic [CHAR_W-1:0]   entry_char;

   modport source (output valid, output func, output entry_index, output entry_char,
                   input ready);
   modport sink (input valid, input func, input entry_index, input entry_char,
                 output ready);
endinterface

>>> sv/kce_rsp_if.sv
// response channel of the enumerator
interface kce_rsp_if;
   import kce_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CAND_W-1:0]     candidate;
   logic [LEN_W-1:0]      candidate_length;
   logic                  exhausted;
   logic [ATTEMPT_W-1:0]  attempt_number;

   modport source (output valid, output candidate, output candidate_length,
                   output exhausted, output attempt_number, input ready);
   modport sink (input valid, input candidate, input candidate_length,
                 input exhausted, input attempt_number, output ready);
endinterface

>>> sv/kce_ram.sv
// generic single write port ram with registered read
module kce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/kce_ctrl.sv
// request sequencing state machine of the enumerator
module kce_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [kce_pkg::FUNC_W-1:0] req_func,
   output logic                      req_ready,
   input  kce_pkg::stat_type         stat,
   output kce_pkg::cmd_type          cmd
);
   import kce_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_FETCH  = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_func == FUNC_NEXT) begin
                  if (stat.done) begin
                     state_in = ST_FINISH;
                  end else begin
                     cmd.start_fetch = 1'b1;
                     state_in = ST_FETCH;
                  end
               end
            end
         end
         ST_FETCH: begin
            cmd.capture = 1'b1;
            if (stat.last_byte) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/kce_datapath.sv
// tables, odometer state, candidate assembly and response register
module kce_datapath #(
   parameter int MAX_LENGTH = 8,
   parameter int ALPHABET_DEPTH = 64,
   parameter int FIRST_LETTER_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kce_pkg::cmd_type              cmd,
   output kce_pkg::stat_type             stat,
   input  logic [kce_pkg::FUNC_W-1:0]     func,
   input  logic [kce_pkg::INDEX_W-1:0]    entry_index,
   input  logic [kce_pkg::CHAR_W-1:0]     entry_char,
   input  logic                          csr_we,
   input  logic [kce_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kce_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [kce_pkg::CAND_W-1:0]     rsp_candidate,
   output logic [kce_pkg::LEN_W-1:0]      rsp_candidate_length,
   output logic                          rsp_exhausted,
   output logic [kce_pkg::ATTEMPT_W-1:0]  rsp_attempt_number
);
   import kce_pkg::*;

   localparam int SLOTS = (MAX_LENGTH > 1) ? MAX_LENGTH - 1 : 1;
   localparam int IW    = $clog2(ALPHABET_DEPTH);
   localparam int FAW   = (FIRST_LETTER_DEPTH > 1) ? $clog2(FIRST_LETTER_DEPTH) : 1;
   localparam int PW    = $clog2(FIRST_LETTER_DEPTH + 1);
   localparam int SW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam int AS_W  = ($clog2(ALPHABET_DEPTH + 1) > CSR_DATA_W) ?
                          $clog2(ALPHABET_DEPTH + 1) : CSR_DATA_W;
   localparam int FC_W  = ($clog2(FIRST_LETTER_DEPTH + 1) > CSR_DATA_W) ?
                          $clog2(FIRST_LETTER_DEPTH + 1) : CSR_DATA_W;

   // configuration
   logic [CSR_DATA_W-1:0] alpha_size_ff;
   logic [CSR_DATA_W-1:0] first_count_ff;
   logic [LEN_W-1:0]      max_len_ff;

   // enumeration state
   logic [IW-1:0]        idx_ff [SLOTS];
   logic [IW-1:0]        idx_in [SLOTS];
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [PW-1:0]        pos_ff, pos_in;
   logic                 done_ff, done_in;
   logic [ATTEMPT_W-1:0] count_ff, count_in;

   // candidate assembly
   logic [SW-1:0]     step_ff;
   logic [CHAR_W-1:0] cand_ff [MAX_LENGTH];

   // response register
   logic                 rsp_valid_ff;
   logic [CAND_W-1:0]    rsp_cand_ff;
   logic [LEN_W-1:0]     rsp_len_ff;
   logic                 rsp_exh_ff;
   logic [ATTEMPT_W-1:0] rsp_attempt_ff;

   logic [AS_W-1:0]   asize_raw, eff_alpha;
   logic [FC_W-1:0]   fcount_raw, eff_count;
   logic [LEN_W-1:0]  eff_mlen;
   logic              carry;
   logic              letter_adv;
   logic              alpha_we, first_we;
   logic [IW-1:0]     alpha_raddr;
   logic [CHAR_W-1:0] alpha_rdata, first_rdata, rd_byte;
   logic [CAND_W-1:0] cand_packed;

   // effective register values
   always_comb begin
      asize_raw  = AS_W'(alpha_size_ff);
      fcount_raw = FC_W'(first_count_ff);
      if (asize_raw == '0) begin
         eff_alpha = AS_W'(1);
      end else if (asize_raw > AS_W'(ALPHABET_DEPTH)) begin
         eff_alpha = AS_W'(ALPHABET_DEPTH);
      end else begin
         eff_alpha = asize_raw;
      end
      if (fcount_raw > FC_W'(FIRST_LETTER_DEPTH)) begin
         eff_count = FC_W'(FIRST_LETTER_DEPTH);
      end else begin
         eff_count = fcount_raw;
      end
      if (max_len_ff == '0) begin
         eff_mlen = LEN_W'(1);
      end else if (max_len_ff > LEN_W'(MAX_LENGTH)) begin
         eff_mlen = LEN_W'(MAX_LENGTH);
      end else begin
         eff_mlen = max_len_ff;
      end
   end

   // tables
   assign alpha_we = cmd.accept && (func == FUNC_LOAD_ALPHA) &&
                     (32'(entry_index) < ALPHABET_DEPTH);
   assign first_we = cmd.accept && (func == FUNC_LOAD_FIRST) &&
                     (32'(entry_index) < FIRST_LETTER_DEPTH);

   always_comb begin
      alpha_raddr = '0;
      for (int s = 0; s < SLOTS; s++) begin
         if (SW'(s) == step_ff) begin
            alpha_raddr = idx_ff[s];
         end
      end
   end

   kce_ram #(.WIDTH(CHAR_W), .DEPTH(ALPHABET_DEPTH)) u_alpha_ram (
      .clock   (clock),
      .wr_en   (alpha_we),
      .wr_addr (IW'(entry_index)),
      .wr_data (entry_char),
      .rd_addr (alpha_raddr),
      .rd_data (alpha_rdata)
   );

   kce_ram #(.WIDTH(CHAR_W), .DEPTH(FIRST_LETTER_DEPTH)) u_first_ram (
      .clock   (clock),
      .wr_en   (first_we),
      .wr_addr (FAW'(entry_index)),
      .wr_data (entry_char),
      .rd_addr (FAW'(pos_ff)),
      .rd_data (first_rdata)
   );

   assign rd_byte = (step_ff == '0) ? first_rdata : alpha_rdata;

   // odometer advance and restart
   always_comb begin
      idx_in     = idx_ff;
      len_in     = len_ff;
      pos_in     = pos_ff;
      done_in    = done_ff;
      count_in   = count_ff;
      carry      = 1'b1;
      letter_adv = 1'b0;
      if (cmd.accept && (func == FUNC_RESTART)) begin
         for (int s = 0; s < SLOTS; s++) begin
            idx_in[s] = '0;
         end
         len_in   = LEN_W'(1);
         pos_in   = '0;
         count_in = '0;
         done_in  = (eff_count == '0);
      end else if (cmd.finish && !done_ff) begin
         count_in = count_ff + ATTEMPT_W'(1);
         if (len_ff <= LEN_W'(1)) begin
            if (eff_mlen > LEN_W'(1)) begin
               idx_in[0] = '0;
               len_in    = LEN_W'(2);
            end else begin
               letter_adv = 1'b1;
            end
         end else begin
            for (int s = SLOTS - 1; s >= 0; s--) begin
               if (carry && (LEN_W'(s) + LEN_W'(1) < len_ff)) begin
                  if (AS_W'(idx_ff[s]) + AS_W'(1) >= eff_alpha) begin
                     idx_in[s] = '0;
                  end else begin
                     idx_in[s] = idx_ff[s] + IW'(1);
                     carry     = 1'b0;
                  end
               end
            end
            if (carry) begin
               if (len_ff < eff_mlen) begin
                  for (int s = 0; s < SLOTS; s++) begin
                     if (LEN_W'(s) + LEN_W'(1) == len_ff) begin
                        idx_in[s] = '0;
                     end
                  end
                  len_in = len_ff + LEN_W'(1);
               end else begin
                  letter_adv = 1'b1;
               end
            end
         end
         if (letter_adv) begin
            for (int s = 0; s < SLOTS; s++) begin
               idx_in[s] = '0;
            end
            len_in  = LEN_W'(1);
            pos_in  = pos_ff + PW'(1);
            done_in = (FC_W'(pos_ff) + FC_W'(1) >= eff_count);
         end
      end
   end

   always_comb begin
      cand_packed = '0;
      for (int b = 0; b < MAX_LENGTH; b++) begin
         cand_packed[CHAR_W*b +: CHAR_W] = cand_ff[b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_size_ff  <= CSR_DATA_W'(1);
         first_count_ff <= '0;
         max_len_ff     <= LEN_W'(8);
         for (int s = 0; s < SLOTS; s++) begin
            idx_ff[s] <= '0;
         end
         len_ff       <= LEN_W'(1);
         pos_ff       <= '0;
         done_ff      <= 1'b1;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_ALPHA_SIZE) begin
               alpha_size_ff <= csr_wdata;
            end else if (csr_index == CSR_FIRST_COUNT) begin
               first_count_ff <= csr_wdata;
            end else if (csr_index == CSR_MAX_LENGTH) begin
               max_len_ff <= csr_wdata[LEN_W-1:0];
            end
         end
         idx_ff   <= idx_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
         done_ff  <= done_in;
         count_ff <= count_in;
         if (cmd.start_fetch) begin
            step_ff <= '0;
         end else if (cmd.capture) begin
            step_ff <= step_ff + SW'(1);
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_fetch) begin
         for (int b = 0; b < MAX_LENGTH; b++) begin
            cand_ff[b] <= '0;
         end
      end else if (cmd.capture) begin
         for (int b = 0; b < MAX_LENGTH; b++) begin
            if (SW'(b) == step_ff) begin
               cand_ff[b] <= rd_byte;
            end
         end
      end
      if (cmd.finish) begin
         if (done_ff) begin
            rsp_cand_ff    <= '0;
            rsp_len_ff     <= '0;
            rsp_exh_ff     <= 1'b1;
            rsp_attempt_ff <= count_ff;
         end else begin
            rsp_cand_ff    <= cand_packed;
            rsp_len_ff     <= len_ff;
            rsp_exh_ff     <= 1'b0;
            rsp_attempt_ff <= count_ff + ATTEMPT_W'(1);
         end
      end
   end

   assign stat.done      = done_ff;
   assign stat.last_byte = (LEN_W'(step_ff) + LEN_W'(1) == len_ff);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_candidate        = rsp_cand_ff;
   assign rsp_candidate_length = rsp_len_ff;
   assign rsp_exhausted        = rsp_exh_ff;
   assign rsp_attempt_number   = rsp_attempt_ff;

endmodule

>>> sv/keyspace_candidate_enumerator_top.sv
// keyspace candidate enumerator top level
//
// requests arrive on req_chan (valid/ready). func selects: load an alphabet
// entry, load a first-letter entry, next candidate, restart. loads and restart
// give no response. next gives one response on rsp_chan. a next request reads
// the first-letter table and then one alphabet entry per suffix character
// through the single read port of each table ram before its response is
// registered; when enumeration is exhausted it skips these reads. the next
// request is taken as soon as the previous one has been placed in the
// response register.
// the response register holds its value while rsp_chan.ready is low; a
// finished next request then waits for the register to drain and no further
// request is taken meanwhile.
// csr_we writes register csr_index: 0 alphabet size, 1 first-letter count,
// 2 max length. write them only while no request is in flight.
// reset (synchronous) returns registers to 1, 0, 8 and marks the enumeration
// exhausted until a restart request; table contents are undefined until loaded.
module keyspace_candidate_enumerator_top #(
   parameter int MAX_LENGTH = 8,
   parameter int ALPHABET_DEPTH = 64,
   parameter int FIRST_LETTER_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   kce_req_if.sink                       req_chan,
   kce_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [kce_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kce_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import kce_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   kce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   kce_datapath #(
      .MAX_LENGTH         (MAX_LENGTH),
      .ALPHABET_DEPTH     (ALPHABET_DEPTH),
      .FIRST_LETTER_DEPTH (FIRST_LETTER_DEPTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .func                 (req_chan.func),
      .entry_index          (req_chan.entry_index),
      .entry_char           (req_chan.entry_char),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .rsp_valid            (rsp_chan.valid),
      .rsp_ready            (rsp_chan.ready),
      .rsp_candidate        (rsp_chan.candidate),
      .rsp_candidate_length (rsp_chan.candidate_length),
      .rsp_exhausted        (rsp_chan.exhausted),
      .rsp_attempt_number   (rsp_chan.attempt_number)
   );

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> stat.out_free)
      else $error("response register overwritten");

   a_fetch_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.start_fetch |=> cmd.capture)
      else $error("fetch did not start after next request");

   a_exhausted_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.exhausted) |->
      (rsp_chan.candidate_length == '0 && rsp_chan.candidate == '0))
      else $error("exhausted response carries a candidate");

   a_live_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.exhausted) |->
      (rsp_chan.candidate_length != '0 &&
       rsp_chan.candidate_length <= LEN_W'(MAX_LENGTH)))
      else $error("candidate length out of range");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.capture || cmd.finish) |-> !cmd.accept)
      else $error("request accepted while a next request is in flight");

endmodule
